// ----- sv/assert_macros.svh -----
// assertion macros shared by the stereo delay filter mix effect rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge outside reset
`define SDFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define SDFM_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ----- sv/sdfm_pkg.sv -----
// types, constants and saturation helpers of the stereo delay filter mix effect
`default_nettype none

package sdfm_pkg;

    localparam int SAMPLE_W = 24;
    localparam int ADDR_W   = 13;
    localparam int DLY_W    = 13;
    localparam int COEF_W   = 32;
    localparam int STATE_W  = 48;
    localparam int MIX_W    = 17;
    localparam int GAIN_W   = 24;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [MIX_W-1:0] MIX_ONE = 17'd65536;

    // register map, index of each register
    typedef enum logic [2:0] {
        REG_SPARK_MIX,
        REG_BLEND_GAIN,
        REG_LP_B0,
        REG_LP_A1,
        REG_LP_A2,
        REG_LEFT_DELAY,
        REG_RIGHT_DELAY,
        REG_TAP_SHORT
    } t_reg_idx;

    // controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_P,
        ST_Y,
        ST_FB1,
        ST_S1,
        ST_S2,
        ST_TG,
        ST_ML1,
        ST_ML2,
        ST_MR1,
        ST_MR2,
        ST_DONE
    } t_state;

    // configuration registers
    typedef struct packed {
        logic        [MIX_W-1:0]  spark_mix;
        logic        [GAIN_W-1:0] blend_gain;
        logic signed [COEF_W-1:0] lp_b0;
        logic signed [COEF_W-1:0] lp_a1;
        logic signed [COEF_W-1:0] lp_a2;
        logic        [DLY_W-1:0]  left_delay;
        logic        [DLY_W-1:0]  right_delay;
        logic        [DLY_W-1:0]  tap_delay_short;
    } t_cfg;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;
        logic load;
        logic calc_p;
        logic calc_y;
        logic calc_fb1;
        logic calc_s1;
        logic calc_s2;
        logic calc_tg;
        logic mix_l1;
        logic mix_l2;
        logic mix_r1;
        logic mix_r2;
        logic out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

    // saturate to the sample width
    function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd8388607;
        lo = -64'sd8388608;
        if (v > hi) begin
            sat_sample = 24'sd8388607;
        end else if (v < lo) begin
            sat_sample = -24'sd8388608;
        end else begin
            sat_sample = v[SAMPLE_W-1:0];
        end
    endfunction

    // saturate to the filter state width
    function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd140737488355327;
        lo = -64'sd140737488355328;
        if (v > hi) begin
            sat_state = 48'sh7FFF_FFFF_FFFF;
        end else if (v < lo) begin
            sat_state = 48'sh8000_0000_0000;
        end else begin
            sat_state = v[STATE_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/stereo_delay_filter_mix_effect_top.sv -----
// top level: apb register file, controller and datapath of the stereo delay effect
// sequence: an accepted pair runs through the states P, Y, FB1, S1, S2, TG, ML1,
//   ML2, MR1 and MR2 and is loaded to the outputs in DONE; a stalled result
//   holds the next in DONE, and a new pair is taken only in IDLE afterwards
// reset: synchronous active low; afterwards a clearing pass zeroes every word of
//   the delay stores before the first input transaction is taken
`default_nettype none

module stereo_delay_filter_mix_effect_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_in_left,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_in_right,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic signed [sdfm_pkg::SAMPLE_W-1:0]      o_out_left,
    output logic signed [sdfm_pkg::SAMPLE_W-1:0]      o_out_right,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sdfm_pkg::PADDR_W-1:0]         paddr,
    input  wire logic [sdfm_pkg::PDATA_W-1:0]         pwdata,
    output logic [sdfm_pkg::PDATA_W-1:0]              prdata,
    output logic                                      pready
);

    sdfm_pkg::t_cfg     r_cfg;
    sdfm_pkg::t_dp_cmd  cmd;
    sdfm_pkg::t_dp_sts  sts;
    sdfm_pkg::t_reg_idx reg_idx;
    logic               wr_en;

    assign reg_idx = sdfm_pkg::t_reg_idx'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spark_mix       <= 17'd0;
            r_cfg.blend_gain      <= 24'd1049;
            r_cfg.lp_b0           <= 32'sd274720;
            r_cfg.lp_a1           <= -32'sd512040000;
            r_cfg.lp_a2           <= 32'sd244703000;
            r_cfg.left_delay      <= 13'd48;
            r_cfg.right_delay     <= 13'd960;
            r_cfg.tap_delay_short <= 13'd2400;
        end else if (wr_en) begin
            case (reg_idx)
                sdfm_pkg::REG_SPARK_MIX:   r_cfg.spark_mix       <= pwdata[16:0];
                sdfm_pkg::REG_BLEND_GAIN:  r_cfg.blend_gain      <= pwdata[23:0];
                sdfm_pkg::REG_LP_B0:       r_cfg.lp_b0           <= pwdata;
                sdfm_pkg::REG_LP_A1:       r_cfg.lp_a1           <= pwdata;
                sdfm_pkg::REG_LP_A2:       r_cfg.lp_a2           <= pwdata;
                sdfm_pkg::REG_LEFT_DELAY:  r_cfg.left_delay      <= pwdata[12:0];
                sdfm_pkg::REG_RIGHT_DELAY: r_cfg.right_delay     <= pwdata[12:0];
                sdfm_pkg::REG_TAP_SHORT:   r_cfg.tap_delay_short <= pwdata[12:0];
                default:                   r_cfg <= r_cfg;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (reg_idx)
            sdfm_pkg::REG_SPARK_MIX:   prdata = 32'(r_cfg.spark_mix);
            sdfm_pkg::REG_BLEND_GAIN:  prdata = 32'(r_cfg.blend_gain);
            sdfm_pkg::REG_LP_B0:       prdata = r_cfg.lp_b0;
            sdfm_pkg::REG_LP_A1:       prdata = r_cfg.lp_a1;
            sdfm_pkg::REG_LP_A2:       prdata = r_cfg.lp_a2;
            sdfm_pkg::REG_LEFT_DELAY:  prdata = 32'(r_cfg.left_delay);
            sdfm_pkg::REG_RIGHT_DELAY: prdata = 32'(r_cfg.right_delay);
            sdfm_pkg::REG_TAP_SHORT:   prdata = 32'(r_cfg.tap_delay_short);
            default:                   prdata = '0;
        endcase
    end

    // sequencing
    sdfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // arithmetic and stores
    sdfm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_left   (i_in_left),
        .i_in_right  (i_in_right),
        .o_out_left  (o_out_left),
        .o_out_right (o_out_right)
    );

endmodule

`default_nettype wire

// ----- sv/sdfm_ctrl.sv -----
// controller state machine sequencing one sample pair through the datapath
`default_nettype none

module sdfm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire sdfm_pkg::t_dp_sts i_sts,
    output sdfm_pkg::t_dp_cmd      o_cmd
);

    sdfm_pkg::t_state r_state;
    sdfm_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sdfm_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sdfm_pkg::ST_CLEAR: if (i_sts.clr_last) n_state = sdfm_pkg::ST_IDLE;
            sdfm_pkg::ST_IDLE:  if (i_valid) n_state = sdfm_pkg::ST_P;
            sdfm_pkg::ST_P:     n_state = sdfm_pkg::ST_Y;
            sdfm_pkg::ST_Y:     n_state = sdfm_pkg::ST_FB1;
            sdfm_pkg::ST_FB1:   n_state = sdfm_pkg::ST_S1;
            sdfm_pkg::ST_S1:    n_state = sdfm_pkg::ST_S2;
            sdfm_pkg::ST_S2:    n_state = sdfm_pkg::ST_TG;
            sdfm_pkg::ST_TG:    n_state = sdfm_pkg::ST_ML1;
            sdfm_pkg::ST_ML1:   n_state = sdfm_pkg::ST_ML2;
            sdfm_pkg::ST_ML2:   n_state = sdfm_pkg::ST_MR1;
            sdfm_pkg::ST_MR1:   n_state = sdfm_pkg::ST_MR2;
            sdfm_pkg::ST_MR2:   n_state = sdfm_pkg::ST_DONE;
            sdfm_pkg::ST_DONE:  if (!r_out_valid || i_ready) n_state = sdfm_pkg::ST_IDLE;
            default:            n_state = sdfm_pkg::ST_CLEAR;
        endcase
    end

    // commands and handshake outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            sdfm_pkg::ST_CLEAR: o_cmd.clear = 1'b1;
            sdfm_pkg::ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            sdfm_pkg::ST_P:    o_cmd.calc_p   = 1'b1;
            sdfm_pkg::ST_Y:    o_cmd.calc_y   = 1'b1;
            sdfm_pkg::ST_FB1:  o_cmd.calc_fb1 = 1'b1;
            sdfm_pkg::ST_S1:   o_cmd.calc_s1  = 1'b1;
            sdfm_pkg::ST_S2:   o_cmd.calc_s2  = 1'b1;
            sdfm_pkg::ST_TG:   o_cmd.calc_tg  = 1'b1;
            sdfm_pkg::ST_ML1:  o_cmd.mix_l1   = 1'b1;
            sdfm_pkg::ST_ML2:  o_cmd.mix_l2   = 1'b1;
            sdfm_pkg::ST_MR1:  o_cmd.mix_r1   = 1'b1;
            sdfm_pkg::ST_MR2:  o_cmd.mix_r2   = 1'b1;
            sdfm_pkg::ST_DONE: o_cmd.out_load = !r_out_valid || i_ready;
            default:           o_cmd = '0;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    `include "assert_macros.svh"

    `SDFM_ASSERT(a_accept_starts, (i_valid && o_ready) |=> (r_state == sdfm_pkg::ST_P), "accepted transaction did not start")
    `SDFM_ASSERT(a_done_fills, (r_state == sdfm_pkg::ST_DONE && !r_out_valid) |=> r_out_valid, "finished result not presented")
    `SDFM_ASSERT_NEVER(a_no_accept_clear, (r_state == sdfm_pkg::ST_CLEAR) && o_ready, "ready during clearing pass")

endmodule

`default_nettype wire

// ----- sv/sdfm_dp.sv -----
// datapath: delay stores, lowpass biquad, wet taps and output mix
`default_nettype none

module sdfm_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire sdfm_pkg::t_cfg                      i_cfg,
    input  wire sdfm_pkg::t_dp_cmd                   i_cmd,
    output sdfm_pkg::t_dp_sts                        o_sts,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_in_left,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_in_right,
    output logic signed [sdfm_pkg::SAMPLE_W-1:0]      o_out_left,
    output logic signed [sdfm_pkg::SAMPLE_W-1:0]      o_out_right
);

    localparam int DEPTH = 2 ** sdfm_pkg::ADDR_W;

    logic signed [sdfm_pkg::SAMPLE_W-1:0] left_mem  [DEPTH];
    logic signed [sdfm_pkg::SAMPLE_W-1:0] right_mem [DEPTH];
    logic signed [sdfm_pkg::SAMPLE_W-1:0] tone_mem  [DEPTH];

    logic        [sdfm_pkg::ADDR_W-1:0]   r_wp;
    logic        [sdfm_pkg::ADDR_W-1:0]   r_clr_addr;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_xl;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_xr;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_center;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_dl;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_dr;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_t1;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_t2;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_y;
    logic signed [35:0]                   r_p;
    logic signed [35:0]                   r_prod;
    logic signed [sdfm_pkg::STATE_W-1:0]  r_s1;
    logic signed [sdfm_pkg::STATE_W-1:0]  r_s2;
    logic signed [24:0]                   r_tone;
    logic signed [49:0]                   r_tg;
    logic signed [41:0]                   r_ma;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_out_l;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] r_out_r;

    logic signed [sdfm_pkg::COEF_W-1:0]   b0;
    logic signed [sdfm_pkg::COEF_W-1:0]   a1;
    logic signed [sdfm_pkg::COEF_W-1:0]   a2;
    logic signed [24:0]                   in_sum;
    logic        [sdfm_pkg::ADDR_W-1:0]   addr_l;
    logic        [sdfm_pkg::ADDR_W-1:0]   addr_r;
    logic        [sdfm_pkg::ADDR_W-1:0]   addr_t1;
    logic        [sdfm_pkg::ADDR_W-1:0]   addr_t2;
    logic        [sdfm_pkg::DLY_W:0]      dly2;
    logic        [sdfm_pkg::ADDR_W-1:0]   wr_addr;
    logic signed [55:0]                   mul_p;
    logic signed [55:0]                   mul_a1;
    logic signed [55:0]                   mul_a2;
    logic signed [48:0]                   full;
    logic signed [40:0]                   y_sh;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] y_c;
    logic signed [49:0]                   s1_sum;
    logic signed [49:0]                   s2_sum;
    logic signed [24:0]                   tap_sum;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] wet;
    logic        [sdfm_pkg::MIX_W-1:0]    mix_m;
    logic        [sdfm_pkg::MIX_W-1:0]    mix_inv;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] mix_x;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] mix_d;
    logic signed [41:0]                   mul_x;
    logic signed [41:0]                   mul_d;
    logic signed [50:0]                   mix_acc;
    logic signed [28:0]                   mix_q;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] mix_o;

    assign b0 = i_cfg.lp_b0;
    assign a1 = i_cfg.lp_a1;
    assign a2 = i_cfg.lp_a2;

    // read addresses behind the write pointer, wrapping in the store
    assign dly2    = {1'b0, i_cfg.tap_delay_short} + {2'b00, i_cfg.tap_delay_short[12:1]};
    assign addr_l  = r_wp - i_cfg.left_delay;
    assign addr_r  = r_wp - i_cfg.right_delay;
    assign addr_t1 = r_wp - i_cfg.tap_delay_short;
    assign addr_t2 = r_wp - dly2[sdfm_pkg::ADDR_W-1:0];
    assign wr_addr = i_cmd.clear ? r_clr_addr : r_wp;

    // channel delay stores
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear || i_cmd.load) begin
            left_mem[wr_addr]  <= i_cmd.clear ? '0 : i_in_left;
            right_mem[wr_addr] <= i_cmd.clear ? '0 : i_in_right;
        end
        if (i_cmd.calc_p) begin
            r_dl <= left_mem[addr_l];
            r_dr <= right_mem[addr_r];
        end
    end

    // filtered signal store with two read taps
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear || i_cmd.calc_y) begin
            tone_mem[wr_addr] <= i_cmd.clear ? '0 : y_c;
        end
        if (i_cmd.calc_fb1) begin
            r_t1 <= tone_mem[addr_t1];
            r_t2 <= tone_mem[addr_t2];
        end
    end

    // biquad arithmetic
    assign in_sum  = 25'(i_in_left) + 25'(i_in_right);
    assign mul_p   = b0 * r_center;
    assign mul_a1  = a1 * r_y;
    assign mul_a2  = a2 * r_y;
    assign full    = 49'(r_p) + 49'(r_s1) + 49'sd128;
    assign y_sh    = full[48:8];
    assign y_c     = sdfm_pkg::sat_sample(64'(y_sh));
    assign s1_sum  = (50'(r_p) <<< 1) - 50'(r_prod) + 50'(r_s2);
    assign s2_sum  = 50'(r_p) - 50'(r_prod);
    assign tap_sum = 25'(r_t1) + 25'(r_t2);
    assign wet     = tap_sum[24:1];

    // dry, delayed and filtered tone mix, one channel at a time
    assign mix_m   = (i_cfg.spark_mix > sdfm_pkg::MIX_ONE) ? sdfm_pkg::MIX_ONE
                                                           : i_cfg.spark_mix;
    assign mix_inv = sdfm_pkg::MIX_ONE - mix_m;
    assign mix_x   = i_cmd.mix_r1 ? r_xr : r_xl;
    assign mix_d   = i_cmd.mix_r2 ? r_dr : r_dl;
    assign mul_x   = mix_x * $signed({1'b0, mix_inv});
    assign mul_d   = mix_d * $signed({1'b0, mix_m});
    assign mix_acc = ((51'(r_ma) + 51'(mul_d)) <<< 6) + 51'(r_tg) + 51'sd2097152;
    assign mix_q   = mix_acc[50:22];
    assign mix_o   = sdfm_pkg::sat_sample(64'(mix_q));

    // control registers: write pointer, clear sweep, filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp       <= '0;
            r_clr_addr <= '0;
            r_s1       <= '0;
            r_s2       <= '0;
        end else begin
            if (i_cmd.clear) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.mix_r2) r_wp <= r_wp + 1'b1;
            if (i_cmd.calc_s1) r_s1 <= sdfm_pkg::sat_state(64'(s1_sum));
            if (i_cmd.calc_s2) r_s2 <= sdfm_pkg::sat_state(64'(s2_sum));
        end
    end

    // payload registers, both outputs change only when a new result is presented
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xl     <= i_in_left;
            r_xr     <= i_in_right;
            r_center <= in_sum[24:1];
        end
        if (i_cmd.calc_p) r_p <= mul_p[55:20];
        if (i_cmd.calc_y) r_y <= y_c;
        if (i_cmd.calc_fb1) r_prod <= mul_a1[55:20];
        if (i_cmd.calc_s1) r_prod <= mul_a2[55:20];
        if (i_cmd.calc_s2) r_tone <= 25'(r_y) + 25'(wet);
        if (i_cmd.calc_tg) r_tg <= r_tone * $signed({1'b0, i_cfg.blend_gain});
        if (i_cmd.mix_l1 || i_cmd.mix_r1) r_ma <= mul_x;
        if (i_cmd.mix_l2) r_out_l <= mix_o;
        if (i_cmd.mix_r2) r_out_r <= mix_o;
        if (i_cmd.out_load) begin
            o_out_left  <= r_out_l;
            o_out_right <= r_out_r;
        end
    end

    assign o_sts.clr_last = &r_clr_addr;

endmodule

`default_nettype wire

// ----- test/stereo_delay_filter_mix_effect_checker.sv -----
// checker: predicts each output sample pair of the effect and compares it with the block
`timescale 1ns / 100ps
`default_nettype none

module stereo_delay_filter_mix_effect_checker (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    input  wire logic                                 i_ready_in,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_in_left,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_in_right,
    input  wire logic                                 i_out_valid,
    input  wire logic                                 i_out_ready,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_out_left,
    input  wire logic signed [sdfm_pkg::SAMPLE_W-1:0] i_out_right,
    input  wire logic                                 i_cfg_we,
    input  wire logic [2:0]                           i_cfg_idx,
    input  wire logic [31:0]                          i_cfg_data,
    output logic [31:0]                               o_fail_count,
    output logic [31:0]                               o_pending
);

    localparam int DEPTH = 8192;

    typedef struct packed {
        logic signed [sdfm_pkg::SAMPLE_W-1:0] left;
        logic signed [sdfm_pkg::SAMPLE_W-1:0] right;
    } t_pair;

    sdfm_pkg::t_cfg cfg;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] left_hist [DEPTH];
    logic signed [sdfm_pkg::SAMPLE_W-1:0] right_hist [DEPTH];
    logic signed [sdfm_pkg::SAMPLE_W-1:0] tone_hist [DEPTH];
    logic [12:0] wr_pos;
    logic signed [63:0] lp_s1;
    logic signed [63:0] lp_s2;
    t_pair pending_pairs [$];

    // floor division by a power of two
    function automatic logic signed [63:0] fshift(input logic signed [63:0] v, input int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] clamp_state(input logic signed [63:0] v);
        if (v > 64'sd140737488355327) return 64'sd140737488355327;
        if (v < -64'sd140737488355328) return -64'sd140737488355328;
        return v;
    endfunction

    function automatic logic signed [63:0] clamp_sample(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    function automatic logic signed [63:0] mix_channel(input logic signed [63:0] x,
            input logic signed [63:0] del, input logic signed [63:0] tone,
            input logic signed [63:0] m);
        logic signed [63:0] acc;
        acc = (x * (64'sd65536 - m) + del * m) * 64 + tone * $signed({40'd0, cfg.blend_gain});
        return clamp_sample(fshift(acc + (64'sd1 <<< 21), 22));
    endfunction

    function automatic logic [12:0] back_pos(input logic [12:0] d);
        return wr_pos - d;
    endfunction

    // predict one sample pair and advance the model state
    task automatic predict_pair(input logic signed [sdfm_pkg::SAMPLE_W-1:0] xl,
            input logic signed [sdfm_pkg::SAMPLE_W-1:0] xr);
        logic signed [63:0] center, p, full, y, dl, dr, t1, t2, wet, m, ol, orr;
        logic [13:0] d2;
        t_pair res;
        center = fshift(64'(xl) + 64'(xr), 1);
        left_hist[wr_pos] = xl;
        right_hist[wr_pos] = xr;
        dl = 64'(left_hist[back_pos(cfg.left_delay)]);
        dr = 64'(right_hist[back_pos(cfg.right_delay)]);
        p = fshift(64'(cfg.lp_b0) * center, 20);
        full = p + lp_s1;
        y = clamp_sample(fshift(full + 64'sd128, 8));
        lp_s1 = clamp_state(2 * p - fshift(64'(cfg.lp_a1) * y, 20) + lp_s2);
        lp_s2 = clamp_state(p - fshift(64'(cfg.lp_a2) * y, 20));
        tone_hist[wr_pos] = y[sdfm_pkg::SAMPLE_W-1:0];
        d2 = {1'b0, cfg.tap_delay_short} + {2'b00, cfg.tap_delay_short[12:1]};
        t1 = 64'(tone_hist[back_pos(cfg.tap_delay_short)]);
        t2 = 64'(tone_hist[back_pos(d2[12:0])]);
        wet = fshift(t1 + t2, 1);
        m = (cfg.spark_mix > sdfm_pkg::MIX_ONE) ? 64'sd65536 : 64'(cfg.spark_mix);
        ol = mix_channel(64'(xl), dl, y + wet, m);
        orr = mix_channel(64'(xr), dr, y + wet, m);
        res.left = ol[sdfm_pkg::SAMPLE_W-1:0];
        res.right = orr[sdfm_pkg::SAMPLE_W-1:0];
        wr_pos = wr_pos + 13'd1;
        pending_pairs.push_back(res);
    endtask

    // watch configuration, input and output transactions
    always @(posedge i_clk) begin
        t_pair want;
        if (!i_rst_n) begin
            cfg = '0;
            cfg.blend_gain = 24'd1049;
            cfg.lp_b0 = 32'sd274720;
            cfg.lp_a1 = -32'sd512040000;
            cfg.lp_a2 = 32'sd244703000;
            cfg.left_delay = 13'd48;
            cfg.right_delay = 13'd960;
            cfg.tap_delay_short = 13'd2400;
            for (int i = 0; i < DEPTH; i++) begin
                left_hist[i] = '0;
                right_hist[i] = '0;
                tone_hist[i] = '0;
            end
            wr_pos = '0;
            lp_s1 = '0;
            lp_s2 = '0;
            pending_pairs.delete();
            o_fail_count <= '0;
        end else begin
            if (i_cfg_we) begin
                case (sdfm_pkg::t_reg_idx'(i_cfg_idx))
                    sdfm_pkg::REG_SPARK_MIX:
                        cfg.spark_mix = i_cfg_data[sdfm_pkg::MIX_W-1:0];
                    sdfm_pkg::REG_BLEND_GAIN:
                        cfg.blend_gain = i_cfg_data[sdfm_pkg::GAIN_W-1:0];
                    sdfm_pkg::REG_LP_B0:       cfg.lp_b0 = i_cfg_data;
                    sdfm_pkg::REG_LP_A1:       cfg.lp_a1 = i_cfg_data;
                    sdfm_pkg::REG_LP_A2:       cfg.lp_a2 = i_cfg_data;
                    sdfm_pkg::REG_LEFT_DELAY:
                        cfg.left_delay = i_cfg_data[sdfm_pkg::DLY_W-1:0];
                    sdfm_pkg::REG_RIGHT_DELAY:
                        cfg.right_delay = i_cfg_data[sdfm_pkg::DLY_W-1:0];
                    sdfm_pkg::REG_TAP_SHORT:
                        cfg.tap_delay_short = i_cfg_data[sdfm_pkg::DLY_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_pairs.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("unexpected output transaction %0d %0d",
                                 i_out_left, i_out_right);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_pairs.pop_front();
                    if (want.left !== i_out_left || want.right !== i_out_right) begin
                        if (o_fail_count < 10)
                            $display("mismatch: expected %0d %0d, got %0d %0d",
                                     want.left, want.right, i_out_left, i_out_right);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && i_ready_in) predict_pair(i_in_left, i_in_right);
        end
        o_pending <= 32'(pending_pairs.size());
    end
endmodule

`default_nettype wire

// ----- test/stereo_delay_filter_mix_effect_top_tb.sv -----
// testbench top: stimulus, register programming and verdict for the stereo delay effect
`timescale 1ns / 100ps
`default_nettype none

module stereo_delay_filter_mix_effect_top_tb;

    localparam int NUM_RANDOM = 700;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] in_left = '0;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] in_right = '0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [sdfm_pkg::PADDR_W-1:0] paddr = '0;
    logic [sdfm_pkg::PDATA_W-1:0] pwdata = '0;
    logic in_ready, res_valid, pready;
    logic signed [sdfm_pkg::SAMPLE_W-1:0] res_left, res_right;
    logic [sdfm_pkg::PDATA_W-1:0] prdata;
    logic [31:0] fail_count, pending;
    logic [31:0] cycle_count = 0;
    logic cfg_we;
    int rx_wait = 0;

    always #10 i_clk = ~i_clk;

    stereo_delay_filter_mix_effect_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_in_left(in_left), .i_in_right(in_right),
        .o_valid(res_valid), .i_ready(out_ready),
        .o_out_left(res_left), .o_out_right(res_right),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    assign cfg_we = psel && penable && pwrite && pready;

    stereo_delay_filter_mix_effect_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_in_left(in_left), .i_in_right(in_right),
        .i_out_valid(res_valid), .i_out_ready(out_ready),
        .i_out_left(res_left), .i_out_right(res_right),
        .i_cfg_we(cfg_we), .i_cfg_idx(paddr[4:2]), .i_cfg_data(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog on total run length
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("stereo_delay_filter_mix_effect_top_tb failed");
            $finish;
        end
    end

    // receiver side: a random number of wait cycles after each transaction
    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            rx_wait <= 0;
        end else if (res_valid && out_ready) begin
            stall = $urandom_range(0, 8);
            out_ready <= (stall == 0);
            rx_wait <= stall;
        end else if (!out_ready) begin
            if (rx_wait <= 1) out_ready <= 1'b1;
            rx_wait <= (rx_wait == 0) ? 0 : rx_wait - 1;
        end
    end

    task automatic reg_write(input sdfm_pkg::t_reg_idx idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // valid drops only when a gap follows; with no gap the next pair goes out at once
    task automatic send_pair(input logic [23:0] l, input logic [23:0] r);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_left <= l;
        in_right <= r;
        do @(posedge i_clk); while (!in_ready);
    endtask

    // wait for every expected pair, then a short tail
    task automatic drain;
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [23:0] rand_sample;
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 255));
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic random_config;
        case ($urandom_range(0, 2))
            0: reg_write(sdfm_pkg::REG_SPARK_MIX, $urandom_range(0, 65536));
            1: reg_write(sdfm_pkg::REG_SPARK_MIX, 32'd65536 + $urandom_range(1, 65535));
            default: reg_write(sdfm_pkg::REG_SPARK_MIX, $urandom_range(0, 131071));
        endcase
        reg_write(sdfm_pkg::REG_BLEND_GAIN, ($urandom_range(0, 1) != 0) ? 32'(24'hFFFFFF)
                                                    : $urandom_range(0, 1 << 21));
        reg_write(sdfm_pkg::REG_LP_B0, ($urandom_range(0, 3) == 0) ? $urandom
                                                    : $urandom_range(0, 1 << 22));
        reg_write(sdfm_pkg::REG_LP_A1, ($urandom_range(0, 3) == 0) ? $urandom
                                                    : 32'(-32'sd512040000));
        reg_write(sdfm_pkg::REG_LP_A2, ($urandom_range(0, 3) == 0) ? $urandom
                                                    : 32'd244703000);
        reg_write(sdfm_pkg::REG_LEFT_DELAY, $urandom_range(0, 40));
        reg_write(sdfm_pkg::REG_RIGHT_DELAY, ($urandom_range(0, 3) == 0) ? 32'd8191
                                                    : $urandom_range(0, 60));
        reg_write(sdfm_pkg::REG_TAP_SHORT, ($urandom_range(0, 3) == 0)
                                                    ? $urandom_range(1, 5460)
                                                    : $urandom_range(1, 30));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings, extremes and a zero left delay
        send_pair(24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h800000, 24'h800000);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h000000, 24'hFFFFFF);
        drain();
        reg_write(sdfm_pkg::REG_SPARK_MIX, 32'd65536);
        reg_write(sdfm_pkg::REG_BLEND_GAIN, 32'hFFFFFF);
        reg_write(sdfm_pkg::REG_LP_B0, 32'h7FFFFFFF);
        reg_write(sdfm_pkg::REG_LP_A1, 32'h80000000);
        reg_write(sdfm_pkg::REG_LP_A2, 32'h7FFFFFFF);
        reg_write(sdfm_pkg::REG_LEFT_DELAY, 32'd0);
        reg_write(sdfm_pkg::REG_RIGHT_DELAY, 32'd8191);
        reg_write(sdfm_pkg::REG_TAP_SHORT, 32'd1);
        for (int i = 0; i < 8; i++) send_pair(i[0] ? 24'h7FFFFF : 24'h800000, 24'h7FFFFF);
        drain();
        // mix above one, tap near the top of its range, most negative b0
        reg_write(sdfm_pkg::REG_SPARK_MIX, 32'h1FFFF);
        reg_write(sdfm_pkg::REG_TAP_SHORT, 32'd5460);
        reg_write(sdfm_pkg::REG_LP_B0, 32'h80000000);
        for (int i = 0; i < 6; i++) send_pair(rand_sample(), rand_sample());
        drain();

        // random phases, each with its own setting
        for (int ph = 0; ph < 10; ph++) begin
            random_config();
            for (int i = 0; i < NUM_RANDOM / 10; i++) send_pair(rand_sample(), rand_sample());
            drain();
        end

        if (fail_count == 0) begin
            $display("stereo_delay_filter_mix_effect_top_tb passed");
        end else begin
            $display("stereo_delay_filter_mix_effect_top_tb failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+sv
sv/sdfm_pkg.sv
sv/sdfm_ctrl.sv
sv/sdfm_dp.sv
sv/stereo_delay_filter_mix_effect_top.sv
test/stereo_delay_filter_mix_effect_checker.sv
test/stereo_delay_filter_mix_effect_top_tb.sv
